@@ sv/ipc_pkg.sv @@
// Package for the interrupt priority controller: line count, register map,
// action codes and the structs passed between the top level and the line cells.
// No dependencies.
package ipc_pkg;

   localparam int IRQ_LINES = 64;
   localparam int LINE_W    = (IRQ_LINES > 1) ? $clog2(IRQ_LINES) : 1;
   localparam int WORD_BITS = 32;
   localparam int PAD_BITS  = 256;

   // register map, bank = offset[11:7]
   localparam logic [4:0] BANK_SET_EN   = 5'h00;  // 0x000
   localparam logic [4:0] BANK_CLR_EN   = 5'h01;  // 0x080
   localparam logic [4:0] BANK_SET_PEND = 5'h02;  // 0x100
   localparam logic [4:0] BANK_CLR_PEND = 5'h03;  // 0x180
   localparam logic [4:0] BANK_ACTIVE   = 5'h04;  // 0x200
   localparam logic [3:0] PAGE_PRIO     = 4'h3;   // 0x300, offset[11:8]
   localparam logic [7:0] PRIO_MASK     = 8'hFF;

   typedef enum logic [2:0] {
      ACT_READ       = 3'd0,
      ACT_WRITE      = 3'd1,
      ACT_SET_PEND   = 3'd2,
      ACT_CLR_PEND   = 3'd3,
      ACT_SET_ACTIVE = 3'd4,
      ACT_CLR_ACTIVE = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_WAIT = 3'b100
   } state_type;

   // per-line update, applied on the cycle a request transaction is taken
   typedef struct packed {
      logic       en_set;
      logic       en_clr;
      logic       pend_set;
      logic       pend_clr;
      logic       act_set;
      logic       act_clr;
      logic       prio_wr;
      logic [7:0] prio_wdata;
   } cell_upd_type;

   // best candidate so far, travelling down the chain
   typedef struct packed {
      logic       found;
      logic [7:0] prio;
      logic [7:0] line;
   } cand_type;

endpackage

@@ sv/ipc_if.sv @@
// Handshake channels for the interrupt priority controller.
// Request and response interfaces; no dependencies.
interface ipc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [11:0] offset;
   logic [31:0] write_data;
   logic [7:0]  irq_line;

   modport source (output valid, action, offset, write_data, irq_line, input ready);
   modport sink   (input valid, action, offset, write_data, irq_line, output ready);
endinterface

interface ipc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        pick_valid;
   logic [7:0]  pick_line;

   modport source (output valid, read_data, pick_valid, pick_line, input ready);
   modport sink   (input valid, read_data, pick_valid, pick_line, output ready);
endinterface

@@ sv/ipc_cell.sv @@
// One interrupt line: enable, pending, active and priority, plus one stage of
// the priority chain. Depends on ipc_pkg.
module ipc_cell
   import ipc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   cell_idx,
   input  cell_upd_type upd,
   input  cand_type     cand_in,
   output cand_type     cand_out,
   output logic         enable,
   output logic         pending,
   output logic         active,
   output logic [7:0]   prio
);

   logic       en_ff, en_in;
   logic       pend_ff, pend_in;
   logic       act_ff, act_in;
   logic [7:0] prio_ff, prio_in;
   cand_type   chain_ff, chain_in;
   logic       elig;
   logic       take;

   always_comb begin
      en_in   = (en_ff   | upd.en_set)   & ~upd.en_clr;
      pend_in = (pend_ff | upd.pend_set) & ~upd.pend_clr;
      act_in  = (act_ff  | upd.act_set)  & ~upd.act_clr;
      prio_in = upd.prio_wr ? upd.prio_wdata : prio_ff;
   end

   // upstream lines have lower numbers, so a tie keeps the incoming candidate
   always_comb begin
      elig = en_ff & pend_ff & ~act_ff;
      take = elig && (!cand_in.found || (prio_ff < cand_in.prio));
      if (take) begin
         chain_in.found = 1'b1;
         chain_in.prio  = prio_ff;
         chain_in.line  = cell_idx;
      end else begin
         chain_in = cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff    <= 1'b0;
         pend_ff  <= 1'b0;
         act_ff   <= 1'b0;
         prio_ff  <= '0;
         chain_ff <= '0;
      end else begin
         en_ff    <= en_in;
         pend_ff  <= pend_in;
         act_ff   <= act_in;
         prio_ff  <= prio_in;
         chain_ff <= chain_in;
      end
   end

   assign cand_out = chain_ff;
   assign enable   = en_ff;
   assign pending  = pend_ff;
   assign active   = act_ff;
   assign prio     = prio_ff;

endmodule

@@ sv/interrupt_priority_controller_unit.sv @@
// Interrupt priority controller: register block plus priority chain.
// Depends on ipc_pkg, ipc_if and ipc_cell.
//
// Each request transaction (bus read, bus write, or a direct set/clear of one
// line's pending or active bit) is applied to the line cells on the cycle it is
// taken. The choice of interrupt then ripples through a chain of IRQ_LINES cells,
// one cell per cycle, and is handed to the output register once the whole chain has
// been passed and that register is free; one request is in flight at a time. A
// response sits in an output register; the next request is taken as soon as the
// chain has handed its result over, even if that response has not been collected.
// Read data is captured when the request is taken. All line state is cleared by
// reset.
module interrupt_priority_controller_unit
   import ipc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ipc_req_if.sink    req,
   ipc_rsp_if.source  rsp
);

   state_type         state_ff, state_in;
   logic [LINE_W-1:0] cnt_ff, cnt_in;
   logic [31:0]       rd_ff, rd_in;
   logic              out_valid_ff, out_valid_in;
   logic [31:0]       out_rd_ff;
   logic              out_pick_ff;
   logic [7:0]        out_line_ff;
   logic              req_fire;
   logic              out_free;
   logic              load_out;

   action_type        act;
   logic [4:0]        bank;
   logic [2:0]        word_idx;
   logic              prio_hit;

   cell_upd_type      upd     [IRQ_LINES];
   cand_type          chain   [IRQ_LINES+1];
   logic [IRQ_LINES-1:0] en_vec, pend_vec, act_vec;
   logic [7:0]        prio_vec [IRQ_LINES];
   logic [PAD_BITS-1:0] en_pad, pend_pad, act_pad;
   logic [7:0]        bit_base;

   assign req_fire = req.valid && req.ready;
   assign act      = action_type'(req.action);
   assign bank     = req.offset[11:7];
   assign word_idx = req.offset[4:2];
   assign prio_hit = (req.offset[11:8] == PAGE_PRIO)
                     && ({1'b0, req.offset[7:0]} < 9'(IRQ_LINES));
   assign bit_base = {word_idx, 5'b0};

   // per-line update decode
   always_comb begin
      for (int i = 0; i < IRQ_LINES; i++) begin
         logic wr;
         logic mbit;
         logic hit;
         wr   = req_fire && (act == ACT_WRITE);
         mbit = (word_idx == 3'(i / WORD_BITS)) && req.write_data[i % WORD_BITS];
         hit  = req_fire && (req.irq_line == 8'(i));
         upd[i].en_set     = wr && (bank == BANK_SET_EN)   && mbit;
         upd[i].en_clr     = wr && (bank == BANK_CLR_EN)   && mbit;
         upd[i].pend_set   = (wr && (bank == BANK_SET_PEND) && mbit)
                             || (hit && (act == ACT_SET_PEND));
         upd[i].pend_clr   = (wr && (bank == BANK_CLR_PEND) && mbit)
                             || (hit && (act == ACT_CLR_PEND));
         upd[i].act_set    = hit && (act == ACT_SET_ACTIVE);
         upd[i].act_clr    = hit && (act == ACT_CLR_ACTIVE);
         upd[i].prio_wr    = wr && prio_hit && (req.offset[7:0] == 8'(i));
         upd[i].prio_wdata = req.write_data[7:0] & PRIO_MASK;
      end
   end

   assign chain[0] = '0;

   for (genvar g = 0; g < IRQ_LINES; g++) begin : g_cell
      ipc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (8'(g)),
         .upd      (upd[g]),
         .cand_in  (chain[g]),
         .cand_out (chain[g+1]),
         .enable   (en_vec[g]),
         .pending  (pend_vec[g]),
         .active   (act_vec[g]),
         .prio     (prio_vec[g])
      );
   end

   // bus read, lines beyond IRQ_LINES read as zero
   always_comb begin
      en_pad   = PAD_BITS'(en_vec);
      pend_pad = PAD_BITS'(pend_vec);
      act_pad  = PAD_BITS'(act_vec);
      rd_in    = rd_ff;
      if (req_fire) begin
         rd_in = '0;
         if (act == ACT_READ) begin
            case (bank)
               BANK_SET_EN, BANK_CLR_EN:     rd_in = en_pad[bit_base +: WORD_BITS];
               BANK_SET_PEND, BANK_CLR_PEND: rd_in = pend_pad[bit_base +: WORD_BITS];
               BANK_ACTIVE:                  rd_in = act_pad[bit_base +: WORD_BITS];
               default: begin
                  if (prio_hit)
                     rd_in = 32'(prio_vec[req.offset[LINE_W-1:0]]);
               end
            endcase
         end
      end
   end

   assign out_free = !out_valid_ff || rsp.ready;
   assign load_out = (state_ff == ST_WAIT) && out_free;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      if (rsp.valid && rsp.ready)
         out_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LINE_W'(IRQ_LINES - 1))
               state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               out_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= rd_in;
      if (load_out) begin
         out_rd_ff   <= rd_ff;
         out_pick_ff <= chain[IRQ_LINES].found;
         out_line_ff <= chain[IRQ_LINES].line;
      end
   end

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = out_valid_ff;
   assign rsp.read_data  = out_rd_ff;
   assign rsp.pick_valid = out_pick_ff;
   assign rsp.pick_line  = out_line_ff;

   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SCAN) && (cnt_ff == '0))
      else $error("scan did not start after request transaction");

   a_rsp_from_wait: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_WAIT))
      else $error("response raised outside the hand-over state");

   a_no_pick_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_pick_ff) |-> (out_line_ff == 8'd0))
      else $error("pick_line non-zero without a pick");

endmodule

@@ test/tb_interrupt_priority_controller_unit.sv @@
// Self-checking testbench for interrupt_priority_controller_unit: a directed table,
// then random bus and line transactions, checked against table rows or a predictor.
// Depends on ipc_pkg, ipc_if and the unit itself.
module tb_interrupt_priority_controller_unit;
   import ipc_pkg::*;

   localparam logic [2:0]  ACT_UNUSED_LO = 3'd6;
   localparam logic [2:0]  ACT_UNUSED_HI = 3'd7;
   localparam logic [11:0] OFS_SET_EN    = {BANK_SET_EN, 7'h00};
   localparam logic [11:0] OFS_CLR_EN    = {BANK_CLR_EN, 7'h00};
   localparam logic [11:0] OFS_SET_PEND  = {BANK_SET_PEND, 7'h00};
   localparam logic [11:0] OFS_CLR_PEND  = {BANK_CLR_PEND, 7'h00};
   localparam logic [11:0] OFS_ACTIVE    = {BANK_ACTIVE, 7'h00};
   localparam logic [11:0] OFS_PRIO      = {PAGE_PRIO, 8'h00};

   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE_WAIT  = 80;     // a little over the chain latency
   localparam int RANDOM_COUNT = 1400;
   localparam int CALM_COUNT   = 200;

   typedef struct packed {
      logic [2:0]  action;
      logic [11:0] offset;
      logic [31:0] write_data;
      logic [7:0]  irq_line;
   } ctl_item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        pick_valid;
      logic [7:0]  pick_line;
   } ctl_result_type;

   typedef struct packed {
      ctl_item_type   item;
      logic           typed;
      ctl_result_type want;
   } dir_row_type;

   logic clock;
   logic reset;

   ipc_req_if req_ch ();
   ipc_rsp_if rsp_ch ();

   interrupt_priority_controller_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // predictor state
   logic [IRQ_LINES-1:0] en_map;
   logic [IRQ_LINES-1:0] pend_map;
   logic [IRQ_LINES-1:0] act_map;
   logic [7:0]           prio_map [IRQ_LINES];

   ctl_result_type awaited_results [$];
   int             fail_count  = 0;
   int             cycle_count = 0;
   int             stall_left  = 0;
   bit             calm_tail   = 1'b0;

   // untyped rows (want left zero) are checked against the predictor
   dir_row_type dir_rows [26] = '{
      '{'{ACT_READ, OFS_SET_EN, 32'h0, 8'd0}, 1'b1, '{32'h0, 1'b0, 8'd0}},
      '{'{ACT_READ, OFS_PRIO + 12'h03F, 32'h0, 8'd0}, 1'b1, '{32'h0, 1'b0, 8'd0}},
      '{'{ACT_WRITE, OFS_SET_EN, 32'hFFFF_FFFF, 8'd0}, 1'b1, '{32'h0, 1'b0, 8'd0}},
      '{'{ACT_WRITE, OFS_SET_EN + 12'h004, 32'hFFFF_FFFF, 8'd0}, 1'b1, '{32'h0, 1'b0, 8'd0}},
      '{'{ACT_WRITE, OFS_SET_EN + 12'h008, 32'hFFFF_FFFF, 8'd0}, 1'b1, '{32'h0, 1'b0, 8'd0}},
      '{'{ACT_READ, OFS_SET_EN + 12'h008, 32'h0, 8'd0}, 1'b1, '{32'h0, 1'b0, 8'd0}},
      '{'{ACT_READ, OFS_CLR_EN + 12'h024, 32'h0, 8'd0}, 1'b1, '{32'hFFFF_FFFF, 1'b0, 8'd0}},
      '{'{ACT_WRITE, OFS_PRIO + 12'h03F, 32'h1234_56FF, 8'd0}, 1'b1, '{32'h0, 1'b0, 8'd0}},
      '{'{ACT_READ, OFS_PRIO + 12'h03F, 32'h0, 8'd0}, 1'b1, '{32'h0000_00FF, 1'b0, 8'd0}},
      '{'{ACT_SET_PEND, OFS_SET_EN, 32'h0, 8'd63}, 1'b1, '{32'h0, 1'b1, 8'd63}},
      '{'{ACT_SET_PEND, OFS_SET_EN, 32'h0, 8'd64}, 1'b1, '{32'h0, 1'b1, 8'd63}},
      '{'{ACT_SET_PEND, OFS_SET_EN, 32'h0, 8'd255}, 1'b1, '{32'h0, 1'b1, 8'd63}},
      '{'{ACT_WRITE, OFS_PRIO, 32'hFFFF_FFFF, 8'd0}, 1'b1, '{32'h0, 1'b1, 8'd63}},
      '{'{ACT_SET_PEND, OFS_SET_EN, 32'h0, 8'd0}, 1'b1, '{32'h0, 1'b1, 8'd0}},
      '{'{ACT_SET_ACTIVE, OFS_SET_EN, 32'h0, 8'd0}, 1'b1, '{32'h0, 1'b1, 8'd63}},
      '{'{ACT_READ, OFS_ACTIVE, 32'h0, 8'd0}, 1'b1, '{32'h1, 1'b1, 8'd63}},
      '{'{ACT_WRITE, OFS_ACTIVE, 32'hFFFF_FFFF, 8'd0}, 1'b1, '{32'h0, 1'b1, 8'd63}},
      '{'{ACT_CLR_ACTIVE, OFS_SET_EN, 32'h0, 8'd0}, 1'b1, '{32'h0, 1'b1, 8'd0}},
      '{'{ACT_CLR_PEND, OFS_SET_EN, 32'h0, 8'd0}, 1'b1, '{32'h0, 1'b1, 8'd63}},
      '{'{ACT_WRITE, OFS_CLR_PEND + 12'h004, 32'h8000_0000, 8'd0}, 1'b1, '{32'h0, 1'b0, 8'd0}},
      '{'{ACT_WRITE, OFS_SET_PEND, 32'hFFFF_FFFF, 8'd0}, 1'b0, '{32'h0, 1'b0, 8'd0}},
      '{'{ACT_WRITE, OFS_CLR_EN, 32'h0000_0002, 8'd0}, 1'b0, '{32'h0, 1'b0, 8'd0}},
      '{'{ACT_UNUSED_LO, OFS_CLR_EN, 32'hFFFF_FFFF, 8'd5}, 1'b1, '{32'h0, 1'b1, 8'd2}},
      '{'{ACT_UNUSED_HI, OFS_PRIO, 32'h0, 8'd2}, 1'b1, '{32'h0, 1'b1, 8'd2}},
      '{'{ACT_READ, OFS_PRIO + 12'(IRQ_LINES), 32'h0, 8'd0}, 1'b1, '{32'h0, 1'b1, 8'd2}},
      '{'{ACT_READ, 12'hFFC, 32'h0, 8'd0}, 1'b1, '{32'h0, 1'b1, 8'd2}}
   };

   always #5 clock = ~clock;

   // 32-bit view of one word of a line map; lines past the end read as zero
   function automatic logic [31:0] word_of(logic [IRQ_LINES-1:0] vec, int w);
      logic [31:0] r;
      int          idx;
      r = '0;
      for (int b = 0; b < 32; b++) begin
         idx = w * 32 + b;
         if (idx < IRQ_LINES) r[b] = vec[idx];
      end
      return r;
   endfunction

   // applies one transaction to the line state, returns read data and the chosen line
   function automatic ctl_result_type apply_and_pick(ctl_item_type it);
      ctl_result_type r;
      logic [4:0]     bank;
      logic [31:0]    m;
      logic [7:0]     lead_prio;
      int             w;
      int             idx;
      int             prio_idx;
      r         = '0;
      lead_prio = '0;
      bank      = it.offset[11:7];
      w         = int'(it.offset[4:2]);
      prio_idx  = int'(it.offset) - int'(OFS_PRIO);
      m         = it.write_data & word_of({IRQ_LINES{1'b1}}, w);
      case (it.action)
         ACT_READ: begin
            if (bank == BANK_SET_EN || bank == BANK_CLR_EN)
               r.read_data = word_of(en_map, w);
            else if (bank == BANK_SET_PEND || bank == BANK_CLR_PEND)
               r.read_data = word_of(pend_map, w);
            else if (bank == BANK_ACTIVE)
               r.read_data = word_of(act_map, w);
            else if (prio_idx >= 0 && prio_idx < IRQ_LINES)
               r.read_data = {24'h0, prio_map[prio_idx]};
         end
         ACT_WRITE: begin
            for (int b = 0; b < 32; b++) begin
               idx = w * 32 + b;
               if (m[b]) begin
                  case (bank)
                     BANK_SET_EN:   en_map[idx]   = 1'b1;
                     BANK_CLR_EN:   en_map[idx]   = 1'b0;
                     BANK_SET_PEND: pend_map[idx] = 1'b1;
                     BANK_CLR_PEND: pend_map[idx] = 1'b0;
                     default: ;
                  endcase
               end
            end
            if (prio_idx >= 0 && prio_idx < IRQ_LINES)
               prio_map[prio_idx] = it.write_data[7:0] & PRIO_MASK;
         end
         ACT_SET_PEND:   if (it.irq_line < IRQ_LINES) pend_map[it.irq_line] = 1'b1;
         ACT_CLR_PEND:   if (it.irq_line < IRQ_LINES) pend_map[it.irq_line] = 1'b0;
         ACT_SET_ACTIVE: if (it.irq_line < IRQ_LINES) act_map[it.irq_line]  = 1'b1;
         ACT_CLR_ACTIVE: if (it.irq_line < IRQ_LINES) act_map[it.irq_line]  = 1'b0;
         default: ;
      endcase
      // strict less-than keeps the lowest line on a tie
      for (int i = 0; i < IRQ_LINES; i++) begin
         if (en_map[i] && pend_map[i] && !act_map[i] &&
             (!r.pick_valid || prio_map[i] < lead_prio)) begin
            r.pick_valid = 1'b1;
            r.pick_line  = 8'(i);
            lead_prio    = prio_map[i];
         end
      end
      return r;
   endfunction

   task automatic send_item(ctl_item_type it, ctl_result_type want);
      req_ch.valid      <= 1'b1;
      req_ch.action     <= it.action;
      req_ch.offset     <= it.offset;
      req_ch.write_data <= it.write_data;
      req_ch.irq_line   <= it.irq_line;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      awaited_results.push_back(want);
   endtask

   task automatic maybe_pause();
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // response side back-pressure
   always @(posedge clock) begin
      if (calm_tail) begin
         rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if ($urandom_range(0, 23) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 15);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      ctl_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_results.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected response read_data %h pick_valid %0d pick_line %0d",
                     $time, rsp_ch.read_data, rsp_ch.pick_valid, rsp_ch.pick_line);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_ch.read_data !== want.read_data ||
                rsp_ch.pick_valid !== want.pick_valid ||
                rsp_ch.pick_line !== want.pick_line) begin
               fail_count++;
               $display("%0t: mismatch exp %h/%0d/%0d got %h/%0d/%0d",
                        $time, want.read_data, want.pick_valid, want.pick_line,
                        rsp_ch.read_data, rsp_ch.pick_valid, rsp_ch.pick_line);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      ctl_item_type it;
      int           sel;
      int           bnk;
      int           wd;
      clock             = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.action     = '0;
      req_ch.offset     = '0;
      req_ch.write_data = '0;
      req_ch.irq_line   = '0;
      rsp_ch.ready      = 1'b0;
      en_map            = '0;
      pend_map          = '0;
      act_map           = '0;
      foreach (prio_map[i]) prio_map[i] = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         it = dir_rows[i].item;
         if (dir_rows[i].typed) begin
            void'(apply_and_pick(it));
            send_item(it, dir_rows[i].want);
         end else begin
            send_item(it, apply_and_pick(it));
         end
         maybe_pause();
      end
      drain();

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         calm_tail = (n >= RANDOM_COUNT - CALM_COUNT);
         sel = $urandom_range(0, 99);
         it.action = (sel < 20) ? ACT_READ :
                     (sel < 55) ? ACT_WRITE :
                     (sel < 70) ? ACT_SET_PEND :
                     (sel < 80) ? ACT_CLR_PEND :
                     (sel < 88) ? ACT_SET_ACTIVE :
                     (sel < 96) ? ACT_CLR_ACTIVE :
                     (sel < 98) ? ACT_UNUSED_LO : ACT_UNUSED_HI;
         it.write_data = $urandom;
         it.irq_line   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, IRQ_LINES - 1));
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            it.offset = 12'($urandom);
         end else if (sel < 4) begin
            // priority page, a few bytes past the last line; small values give ties
            it.offset = OFS_PRIO + 12'($urandom_range(0, IRQ_LINES + 7));
            case ($urandom_range(0, 3))
               0:       it.write_data[7:0] = PRIO_MASK;
               1, 2:    it.write_data[7:0] = 8'($urandom_range(0, 3));
               default: ;
            endcase
         end else begin
            bnk = $urandom_range(0, 5);
            wd  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 1);
            it.offset = {5'(bnk), 5'(wd), 2'($urandom_range(0, 3))};
            // sparse clear masks so that lines stay eligible
            if (5'(bnk) == BANK_CLR_EN || 5'(bnk) == BANK_CLR_PEND)
               it.write_data = $urandom & $urandom & $urandom;
         end
         send_item(it, apply_and_pick(it));
         if (n == RANDOM_COUNT / 2)
            drain();
         else
            maybe_pause();
      end

      drain();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ sim.f @@
sv/ipc_pkg.sv
sv/ipc_if.sv
sv/ipc_cell.sv
sv/interrupt_priority_controller_unit.sv
test/tb_interrupt_priority_controller_unit.sv
